### hw/rtl/szcpf_pkg.sv
package szcpf_pkg;

	// fixed field widths
	localparam int SAMPLE_W  = 16;
	localparam int MINR_W    = 16;
	localparam int POS_W     = 24;
	localparam int FRAC_BITS = 8;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;

	// register map, index taken from paddr above the byte offset
	localparam logic REG_MIN_RADIUS = 1'b0;

	// shared add/subtract unit operation
	typedef enum logic {
		UNIT_ADD = 1'b0,
		UNIT_SUB = 1'b1
	} unit_op_t;

endpackage

### hw/rtl/slope_zero_crossing_peak_finder_core.sv
// channel   direction  signals
// config    in/out     psel penable pwrite paddr pwdata prdata pready (APB, min_radius at 0x0)
// item      in         item_valid item_ready sample last
// result    out        result_valid result_ready peak_position peak_found end_of_profile
//                      too_short
//
// an item is taken while the core idles; once a full window is held past min_radius the slope sum
// steps through all 2*HALF_WINDOW+1 taps on the shared adder, then a scan state follows
// a finished crossing adds a multiply state and a restoring divide loop on the same adder,
// then a result state; the divide loop dominates
// reset clears control and profile state; min_radius resets to zero
// item_ready stays low while an item is in work or its result waits for the output register
module slope_zero_crossing_peak_finder_core #(
	parameter int HALF_WINDOW = 7,
	parameter int MAX_SAMPLES = 65536
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [szcpf_pkg::ADDR_W-1:0]     paddr,
	input  logic [szcpf_pkg::DATA_W-1:0]     pwdata,
	output logic [szcpf_pkg::DATA_W-1:0]     prdata,
	output logic                             pready,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  logic [szcpf_pkg::SAMPLE_W-1:0]   sample,
	input  logic                             last,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic [szcpf_pkg::POS_W-1:0]      peak_position,
	output logic                             peak_found,
	output logic                             end_of_profile,
	output logic                             too_short
);

	localparam int WIN     = 2 * HALF_WINDOW + 1;
	localparam int KW      = $clog2(WIN);
	localparam int MAXSUM  = ((1 << szcpf_pkg::SAMPLE_W) - 1) * HALF_WINDOW * (HALF_WINDOW + 1) / 2;
	localparam int SW      = $clog2(MAXSUM + 1) + 1;
	localparam int UW      = SW + 2;
	localparam int IW      = $clog2(MAX_SAMPLES);
	localparam int CNTW    = $clog2(MAX_SAMPLES + 1);
	localparam int QW      = IW + szcpf_pkg::FRAC_BITS;
	localparam int DCW     = $clog2(QW);
	localparam int PW      = IW + SW - 1;
	localparam int LIMW    = (CNTW > szcpf_pkg::MINR_W ? CNTW : szcpf_pkg::MINR_W) + 1;
	localparam int TW      = szcpf_pkg::SAMPLE_W + KW + 2;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SLOPE  = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_MUL    = 6'b001000,
		ST_DIV    = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t                            state_q;
	logic [szcpf_pkg::MINR_W-1:0]      minr_q;
	logic [szcpf_pkg::SAMPLE_W-1:0]    win_q [WIN];
	logic [CNTW-1:0]                   count_q;
	logic signed [SW-1:0]              prev_q;
	logic                              prev_valid_q;
	logic                              seek_q;
	logic [IW-1:0]                     start_q;
	logic signed [SW-1:0]              sslope_q;
	logic [IW-1:0]                     centre_q;
	logic [KW-1:0]                     k_q;
	logic signed [SW-1:0]              acc_q;
	logic [IW-1:0]                     span_q;
	logic [SW-1:0]                     den_q;
	logic [SW-1:0]                     rem_q;
	logic [QW-1:0]                     lo_q;
	logic [DCW-1:0]                    step_q;
	logic                              end_q;
	logic                              short_q;

	logic                              res_valid_q;
	logic [szcpf_pkg::POS_W-1:0]       res_pos_q;
	logic                              res_found_q;
	logic                              res_end_q;
	logic                              res_short_q;

	// apb register access
	logic cfg_write;
	assign cfg_write = psel & penable & pwrite & pready &
		(paddr[szcpf_pkg::ADDR_W-1] == szcpf_pkg::REG_MIN_RADIUS);
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr[szcpf_pkg::ADDR_W-1] == szcpf_pkg::REG_MIN_RADIUS) begin
			prdata = szcpf_pkg::DATA_W'(minr_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minr_q <= '0;
		end else if (cfg_write) begin
			minr_q <= pwdata[szcpf_pkg::MINR_W-1:0];
		end
	end

	// request acceptance and the conditions decided on entry
	logic                  accept;
	logic                  taken;
	logic [CNTW-1:0]       count_n;
	logic                  centre_ok;
	logic                  short_n;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid & item_ready;
	assign taken      = (count_q < CNTW'(MAX_SAMPLES));
	assign count_n    = count_q + CNTW'(taken);
	assign centre_ok  = (LIMW'(count_q) >= LIMW'(minr_q) + LIMW'(2 * HALF_WINDOW));
	assign short_n    = (LIMW'(count_n) < LIMW'(minr_q) + LIMW'(WIN));

	// one slope tap: (k - H) * window[k]
	logic signed [KW:0]    coef;
	logic signed [TW-1:0]  term;
	logic [SW-1:0]         term_sw;
	assign coef    = $signed({1'b0, k_q}) - $signed((KW + 1)'(HALF_WINDOW));
	assign term    = $signed({1'b0, win_q[k_q]}) * coef;
	assign term_sw = term[SW-1:0];

	// crossing tracking on the fresh slope
	logic signed [SW-1:0]  n_cur;
	logic                  start_cond;
	logic                  seek_n;
	logic [IW-1:0]         start_n;
	logic signed [SW-1:0]  sslope_n;
	logic                  finish;
	assign n_cur      = acc_q;
	assign start_cond = prev_valid_q & ~seek_q & (prev_q > 0) & (n_cur <= 0);
	assign seek_n     = seek_q | start_cond;
	assign start_n    = start_cond ? (centre_q - IW'(1)) : start_q;
	assign sslope_n   = start_cond ? prev_q : sslope_q;
	assign finish     = prev_valid_q & seek_n & (prev_q >= 0) & (n_cur < 0);

	// shared adder operand selection
	szcpf_pkg::unit_op_t unit_op;
	logic [UW-1:0]       unit_a;
	logic [UW-1:0]       unit_b;
	logic [UW-1:0]       unit_sum;

	always_comb begin
		case (state_q)
			ST_SLOPE: begin
				unit_op = szcpf_pkg::UNIT_ADD;
				unit_a  = {{2{acc_q[SW-1]}}, acc_q};
				unit_b  = {{2{term_sw[SW-1]}}, term_sw};
			end
			ST_SCAN: begin
				unit_op = szcpf_pkg::UNIT_SUB;
				unit_a  = {{2{sslope_n[SW-1]}}, sslope_n};
				unit_b  = {{2{n_cur[SW-1]}}, n_cur};
			end
			ST_DIV: begin
				unit_op = szcpf_pkg::UNIT_SUB;
				unit_a  = {1'b0, rem_q, lo_q[QW-1]};
				unit_b  = {2'b00, den_q};
			end
			default: begin
				unit_op = szcpf_pkg::UNIT_ADD;
				unit_a  = '0;
				unit_b  = '0;
			end
		endcase
	end

	szcpf_addsub #(
		.W (UW)
	) u_addsub (
		.op  (unit_op),
		.a   (unit_a),
		.b   (unit_b),
		.sum (unit_sum)
	);

	// span times start slope, fed to the divider
	logic [PW-1:0] prod;
	assign prod = PW'(span_q) * PW'(sslope_q[SW-2:0]);

	// interpolated position and result slot
	logic [QW-1:0]                 pos_q16;
	logic [szcpf_pkg::POS_W-1:0]   pos;
	logic                          pos_ok;
	logic                          slot_free;
	assign pos_q16   = {start_q, {szcpf_pkg::FRAC_BITS{1'b0}}} + lo_q;
	assign pos       = szcpf_pkg::POS_W'(pos_q16);
	assign pos_ok    = (pos >= {minr_q, {szcpf_pkg::FRAC_BITS{1'b0}}});
	assign slot_free = ~res_valid_q | result_ready;

	// sample window shift line
	always_ff @(posedge clk) begin
		if (accept && taken) begin
			for (int i = 0; i < WIN - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[WIN-1] <= sample;
		end
	end

	// sequencer and profile state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			seek_q       <= 1'b0;
			start_q      <= '0;
			sslope_q     <= '0;
			end_q        <= 1'b0;
			short_q      <= 1'b0;
			k_q          <= '0;
			step_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (last) begin
							short_q      <= short_n;
							end_q        <= 1'b1;
							count_q      <= '0;
							prev_q       <= '0;
							prev_valid_q <= 1'b0;
							seek_q       <= 1'b0;
							start_q      <= '0;
							sslope_q     <= '0;
							state_q      <= ST_FINISH;
						end else if (taken) begin
							count_q <= count_n;
							end_q   <= 1'b0;
							if (centre_ok) begin
								k_q     <= '0;
								state_q <= ST_SLOPE;
							end
						end
					end
				end
				ST_SLOPE: begin
					k_q <= k_q + KW'(1);
					if (k_q == KW'(WIN - 1)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					prev_q       <= n_cur;
					prev_valid_q <= 1'b1;
					start_q      <= start_n;
					sslope_q     <= sslope_n;
					if (finish) begin
						seek_q  <= 1'b0;
						state_q <= ST_MUL;
					end else begin
						seek_q  <= seek_n;
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + DCW'(1);
					if (step_q == DCW'(QW - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (end_q) begin
						if (slot_free) begin
							state_q <= ST_IDLE;
						end
					end else if (!pos_ok || slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers of the slope and divide loops
	always_ff @(posedge clk) begin
		if (accept) begin
			centre_q <= IW'(count_q - CNTW'(HALF_WINDOW));
			acc_q    <= '0;
		end
		if (state_q == ST_SLOPE) begin
			acc_q <= unit_sum[SW-1:0];
		end
		if (state_q == ST_SCAN) begin
			span_q <= centre_q - start_n;
			den_q  <= unit_sum[SW-1:0];
		end
		if (state_q == ST_MUL) begin
			rem_q <= SW'(prod[PW-1:IW]);
			lo_q  <= {prod[IW-1:0], {szcpf_pkg::FRAC_BITS{1'b0}}};
		end
		// restoring divide step, quotient shifts in behind the dividend bits
		if (state_q == ST_DIV) begin
			if (!unit_sum[UW-1]) begin
				rem_q <= unit_sum[SW-1:0];
			end else begin
				rem_q <= {rem_q[SW-2:0], lo_q[QW-1]};
			end
			lo_q <= {lo_q[QW-2:0], ~unit_sum[UW-1]};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && slot_free && (end_q || pos_ok)) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && slot_free) begin
			if (end_q) begin
				res_pos_q   <= '0;
				res_found_q <= 1'b0;
				res_end_q   <= 1'b1;
				res_short_q <= short_q;
			end else begin
				res_pos_q   <= pos;
				res_found_q <= 1'b1;
				res_end_q   <= 1'b0;
				res_short_q <= 1'b0;
			end
		end
	end

	assign result_valid   = res_valid_q;
	assign peak_position  = res_pos_q;
	assign peak_found     = res_found_q;
	assign end_of_profile = res_end_q;
	assign too_short      = res_short_q;

endmodule

### hw/rtl/szcpf_addsub.sv
module szcpf_addsub #(
	parameter int W = 24
) (
	input  szcpf_pkg::unit_op_t op,
	input  logic [W-1:0]        a,
	input  logic [W-1:0]        b,
	output logic [W-1:0]        sum
);

	logic [W-1:0] b_eff;
	logic         cin;

	// two's complement subtract through inverted operand and carry in
	always_comb begin
		case (op)
			szcpf_pkg::UNIT_SUB: begin
				b_eff = ~b;
				cin   = 1'b1;
			end
			default: begin
				b_eff = b;
				cin   = 1'b0;
			end
		endcase
	end

	assign sum = a + b_eff + W'(cin);

endmodule
